>>> design/rational_arithmetic_unit_assert.svh
// Assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
// Implication checked on every clock, off during reset
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau assertion failed");
// Next-cycle implication
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau assertion failed");
`endif

>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes and the default word width.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;
    localparam int ACT_BITS      = 3;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_NORM = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_LESS = 3'd5,
        ACT_NEG  = 3'd6,
        ACT_NONE = 3'd7
    } t_action;

    typedef struct packed {
        logic [ACT_BITS-1:0]   action;
        logic [FIELD_BITS-1:0] a_num;
        logic [FIELD_BITS-1:0] a_den;
        logic [FIELD_BITS-1:0] b_num;
        logic [FIELD_BITS-1:0] b_den;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_BITS-1:0] res_num;
        logic [FIELD_BITS-1:0] res_den;
        logic                  is_less;
    } t_out_word;
endpackage

>>> design/rau_if.sv
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if: valid-ready channels of the unit
// Each carries one word per handshake.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic              valid;
    logic              ready;
    rau_pkg::t_in_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rau_out_if;
    logic               valid;
    logic               ready;
    rau_pkg::t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/rau_divu.sv
// ----------------------------------------------------------------------------
// rau_divu: shared restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divu #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, r_rem, r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    // shift in next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quot[W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (w_diff[W]) begin
                    r_rem  <= w_trial[W-1:0];
                    r_quot <= {r_quot[W-2:0], 1'b0};
                end else begin
                    r_rem  <= w_diff[W-1:0];
                    r_quot <= {r_quot[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

>>> design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction arithmetic with GCD reduction
// Sequencer around one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in carries an action code and two fractions A and B.
//   Output channel o_out carries one reduced fraction and a less-than flag
//   per input word. Normalize, add, subtract, multiply, divide, negate,
//   and less-than are supported; all arithmetic wraps to WORD_BITS bits.
//   The unit takes one word at a time and is not ready while it works.
//   Each reduction runs Euclid's GCD on the shared divider, one division
//   per modulo step, then two quotient divisions; a zero numerator or
//   denominator skips the divider. A word reduces A, B and, for every
//   action but normalize, less-than and the unused code, the result;
//   operand selection, the products and the output register come on top.
//   The divider loop sets the run time, which grows with the number of
//   Euclid steps, about 45 at worst for 32-bit words. The next word can
//   be taken in the cycle after the result is accepted.
//   After reset the unit is idle and ready. If the receiver stalls, the
//   result stays in the output register and no new word is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    localparam int W = WORD_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_NSETUP, S_GSTART, S_GWAIT, S_Q1START, S_Q1WAIT,
        S_Q2START, S_Q2WAIT, S_NDONE, S_OP, S_M1, S_M2, S_M3, S_M4,
        S_COMB, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_A, PH_B, PH_R} t_phase;

    t_state        r_state;
    t_phase        r_phase;
    t_action       r_act;
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic [W-1:0]  r_nn, r_nd;       // fraction being reduced
    logic [W-1:0]  r_gx, r_gy;       // Euclid pair
    logic [W-1:0]  r_qn;
    logic [W-1:0]  r_p1, r_p2, r_p3;
    logic [W-1:0]  r_res_n, r_res_d;
    logic          r_less;
    logic          r_out_valid;

    // shared units
    logic          w_dstart;
    logic [W-1:0]  w_dvd, w_dvs, w_quot, w_rem;
    logic          w_ddone;
    logic [W-1:0]  r_ma, r_mb;
    logic [W-1:0]  w_prod;

    rau_divu #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_dividend(w_dvd), .i_divisor(w_dvs), .o_done(w_ddone),
        .o_quot(w_quot), .o_rem(w_rem)
    );

    // one wrapped multiplier, operands registered
    logic [2*W-1:0] w_full;
    assign w_full = r_ma * r_mb;
    assign w_prod = w_full[W-1:0];

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] ext(input logic [FIELD_BITS-1:0] v);
        logic [W+FIELD_BITS-1:0] t;
        t = {{W{v[FIELD_BITS-1]}}, v};
        return t[W-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] trunc(input logic [W-1:0] v);
        logic [W+FIELD_BITS-1:0] t;
        t = {{FIELD_BITS{v[W-1]}}, v};
        return t[FIELD_BITS-1:0];
    endfunction

    // divider operand select
    always_comb begin
        w_dstart = 1'b0;
        w_dvd    = r_gy;
        w_dvs    = r_gx;
        unique case (r_state)
            S_GSTART:  w_dstart = 1'b1;
            S_Q1START: begin
                w_dstart = 1'b1;
                w_dvd    = mag(r_nn);
                w_dvs    = r_gy;
            end
            S_Q2START: begin
                w_dstart = 1'b1;
                w_dvd    = mag(r_nd);
                w_dvs    = r_gy;
            end
            default: ;
        endcase
    end

    assign i_in.ready    = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = '{res_num: trunc(r_res_n), res_den: trunc(r_res_d),
                             is_less: r_less};

    logic [W-1:0] w_sign;
    assign w_sign = {1'b1, {(W-1){1'b0}}};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= PH_A;
            r_act       <= ACT_NORM;
        end else begin
            if (o_out.valid && o_out.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    r_act   <= t_action'(i_in.payload.action);
                    r_an    <= ext(i_in.payload.a_num);
                    r_ad    <= ext(i_in.payload.a_den);
                    r_bn    <= ext(i_in.payload.b_num);
                    r_bd    <= ext(i_in.payload.b_den);
                    r_nn    <= ext(i_in.payload.a_num);
                    r_nd    <= ext(i_in.payload.a_den);
                    r_phase <= PH_A;
                    r_state <= S_NSETUP;
                end
                // special cases, else seed Euclid
                S_NSETUP: begin
                    if (r_nd == '0) begin
                        r_nd    <= W'(1);
                        r_state <= S_NDONE;
                    end else if (r_nn == '0) begin
                        r_state <= S_NDONE;
                    end else begin
                        r_gx    <= mag(r_nn);
                        r_gy    <= mag(r_nd);
                        r_state <= S_GSTART;
                    end
                end
                S_GSTART: r_state <= S_GWAIT;
                S_GWAIT: if (w_ddone) begin
                    r_gy <= r_gx;
                    r_gx <= w_rem;
                    r_state <= (w_rem == '0) ? S_Q1START : S_GSTART;
                end
                S_Q1START: r_state <= S_Q1WAIT;
                S_Q1WAIT: if (w_ddone) begin
                    r_qn    <= w_quot;
                    r_state <= S_Q2START;
                end
                S_Q2START: r_state <= S_Q2WAIT;
                S_Q2WAIT: if (w_ddone) begin
                    // signs: n flips its sign if d is negative, d is made positive
                    r_nn <= (r_nn[W-1] ^ r_nd[W-1]) ? (~r_qn + 1'b1) : r_qn;
                    r_nd <= w_quot;
                    r_state <= S_NDONE;
                end
                S_NDONE: begin
                    unique case (r_phase)
                        PH_A: begin
                            r_an    <= r_nn;
                            r_ad    <= r_nd;
                            r_nn    <= r_bn;
                            r_nd    <= r_bd;
                            r_phase <= PH_B;
                            r_state <= S_NSETUP;
                        end
                        PH_B: begin
                            r_bn    <= r_nn;
                            r_bd    <= r_nd;
                            r_state <= S_OP;
                        end
                        default: begin
                            r_res_n     <= r_nn;
                            r_res_d     <= r_nd;
                            r_less      <= 1'b0;
                            r_state     <= S_OUT;
                        end
                    endcase
                end
                // shortcut actions, else pick operands for first product
                S_OP: begin
                    r_phase <= PH_R;
                    unique case (r_act)
                        ACT_NORM: begin
                            r_res_n <= r_an;
                            r_res_d <= r_ad;
                            r_less  <= 1'b0;
                            r_state <= S_OUT;
                        end
                        ACT_NEG: begin
                            r_nn    <= ~r_an + 1'b1;
                            r_nd    <= r_ad;
                            r_state <= S_NSETUP;
                        end
                        ACT_ADD, ACT_SUB: begin
                            if (r_ad == r_bd) begin
                                r_nn <= (r_act == ACT_ADD) ? r_an + r_bn : r_an - r_bn;
                                r_nd <= r_bd;
                                r_state <= S_NSETUP;
                            end else begin
                                r_ma <= r_an; r_mb <= r_bd; r_state <= S_M1;
                            end
                        end
                        ACT_MUL: begin
                            r_ma <= r_an; r_mb <= r_bn; r_state <= S_M1;
                        end
                        ACT_DIV, ACT_LESS: begin
                            r_ma <= r_an; r_mb <= r_bd; r_state <= S_M1;
                        end
                        default: begin
                            r_res_n <= '0;
                            r_res_d <= W'(1);
                            r_less  <= 1'b0;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_M1: begin
                    r_p1 <= w_prod;
                    unique case (r_act)
                        ACT_ADD, ACT_SUB, ACT_DIV, ACT_LESS: begin
                            r_ma <= r_ad; r_mb <= r_bn;
                        end
                        default: begin
                            r_ma <= r_ad; r_mb <= r_bd;
                        end
                    endcase
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_p2    <= w_prod;
                    r_ma    <= r_ad;
                    r_mb    <= r_bd;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_p3    <= w_prod;
                    r_state <= S_COMB;
                end
                // combine products, or compare them for less-than
                S_COMB: begin
                    unique case (r_act)
                        ACT_ADD: begin
                            r_nn    <= r_p1 + r_p2;
                            r_nd    <= r_p3;
                            r_state <= S_NSETUP;
                        end
                        ACT_SUB: begin
                            r_nn    <= r_p1 - r_p2;
                            r_nd    <= r_p3;
                            r_state <= S_NSETUP;
                        end
                        ACT_MUL, ACT_DIV: begin
                            r_nn    <= r_p1;
                            r_nd    <= r_p2;
                            r_state <= S_NSETUP;
                        end
                        default: begin
                            r_res_n <= '0;
                            r_res_d <= W'(1);
                            r_less  <= (r_p1 ^ w_sign) < (r_p2 ^ w_sign);
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_M4: r_state <= S_COMB;
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "rational_arithmetic_unit_assert.svh"

    `RAU_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready)
    `RAU_ASSERT_NEXT(a_out_from_out, i_clk, i_rst_n, r_state == S_OUT, r_out_valid)
    `RAU_ASSERT_IMP(a_res_den_nz, i_clk, i_rst_n, r_out_valid && r_act != ACT_NORM,
        r_res_d != '0 || r_act == ACT_NEG || r_act == ACT_ADD || r_act == ACT_SUB
        || r_act == ACT_MUL || r_act == ACT_DIV)
endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rational arithmetic unit
// Sends action words with two fractions through the valid-ready input,
// predicts each reduced fraction and less-than flag, and checks every
// output word in order. The sender runs in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int          N_RANDOM    = 1800;
    // Idle cycles after the last checked word
    localparam int          DRAIN_WAIT  = 6000;
    localparam longint      CYCLE_LIMIT = 40_000_000;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
    } t_frac;

    logic i_clk;
    logic i_rst_n;
    int   n_errors;
    longint n_cycles;
    int   burst_left;
    t_out_word pending_results[$];

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Drive every input to a known value from time zero
    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end
    initial n_cycles = 0;

    // Euclid on unsigned magnitudes
    function automatic logic [31:0] gcd_mag(logic [31:0] x, logic [31:0] y);
        logic [31:0] t;
        while (x != 0) begin
            t = y % x;
            y = x;
            x = t;
        end
        return y;
    endfunction

    // Bring n/d to normal form
    function automatic t_frac reduce_fraction(logic [31:0] n, logic [31:0] d);
        t_frac r;
        logic [31:0] mn, md, g, qn, qd;
        if (d == 0) begin
            r.num = n;
            r.den = 32'd1;
        end else if (n != 0) begin
            mn = n[31] ? -n : n;
            md = d[31] ? -d : d;
            g  = gcd_mag(mn, md);
            qn = mn / g;
            qd = md / g;
            r.num = n[31] ? -qn : qn;
            r.den = d[31] ? -qd : qd;
            if (d[31]) begin
                r.num = -r.num;
                r.den = -r.den;
            end
        end else begin
            r.num = '0;
            r.den = d;
        end
        return r;
    endfunction

    // Expected output word for one input word
    function automatic t_out_word predict_fraction_op(t_in_word w);
        t_frac a, b, r;
        t_out_word o;
        logic less;
        a = reduce_fraction(w.a_num, w.a_den);
        b = reduce_fraction(w.b_num, w.b_den);
        r = '{num: 32'd0, den: 32'd1};
        less = 1'b0;
        case (t_action'(w.action))
            ACT_NORM: r = a;
            ACT_ADD: begin
                if (a.den != b.den)
                    r = reduce_fraction(a.den * b.num + a.num * b.den, a.den * b.den);
                else
                    r = reduce_fraction(a.num + b.num, b.den);
            end
            ACT_SUB: begin
                if (a.den != b.den)
                    r = reduce_fraction(a.num * b.den - a.den * b.num, a.den * b.den);
                else
                    r = reduce_fraction(a.num - b.num, b.den);
            end
            ACT_MUL:  r = reduce_fraction(a.num * b.num, a.den * b.den);
            ACT_DIV:  r = reduce_fraction(a.num * b.den, a.den * b.num);
            ACT_LESS: less = $signed(a.num * b.den) < $signed(a.den * b.num);
            ACT_NEG:  r = reduce_fraction(-a.num, a.den);
            default: ;
        endcase
        o.res_num = r.num;
        o.res_den = r.den;
        o.is_less = less;
        return o;
    endfunction

    // Offer one word, hold it until taken, then maybe pause the stream
    task automatic send_word(t_action act, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        t_in_word w;
        w.action = act;
        w.a_num  = an;
        w.a_den  = ad;
        w.b_num  = bn;
        w.b_den  = bd;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_fraction_op(w));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    // Receiver stall pattern: mode 0 always ready, mode 1 mostly ready, mode 2 mostly stalled; modes change at random
    int stall_mode;
    int stall_count;
    always @(posedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_count <= $urandom_range(100, 600);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end
    initial begin
        stall_mode  = 0;
        stall_count = 0;
    end

    // Check each accepted output word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word exp_w;
        t_out_word got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word num=%h den=%h less=%b", $time,
                         got.res_num, got.res_den, got.is_less);
                n_errors++;
            end else begin
                exp_w = pending_results.pop_front();
                if (got.res_num !== exp_w.res_num) begin
                    $display("%0t: res_num expected %h actual %h", $time,
                             exp_w.res_num, got.res_num);
                    n_errors++;
                end
                if (got.res_den !== exp_w.res_den) begin
                    $display("%0t: res_den expected %h actual %h", $time,
                             exp_w.res_den, got.res_den);
                    n_errors++;
                end
                if (got.is_less !== exp_w.is_less) begin
                    $display("%0t: is_less expected %b actual %b", $time,
                             exp_w.is_less, got.is_less);
                    n_errors++;
                end
            end
        end
    end

    // Operand value: mostly small, with extremes and full-range noise
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hffff_ffff;
            4:       return $urandom();
            5:       return 32'd1 << $urandom_range(0, 31);
            6:       return $urandom_range(0, 100000) - 50000;
            default: return $urandom_range(0, 60) - 30;
        endcase
    endfunction

    task automatic test_extremes();
        send_word(ACT_NORM, 32'h8000_0000, 32'h8000_0000, 0, 1);
        send_word(ACT_NORM, 32'h7fff_ffff, 32'h8000_0000, 0, 1);
        send_word(ACT_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 1);
        send_word(ACT_MUL,  32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_word(ACT_ADD,  32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
        send_word(ACT_SUB,  32'h8000_0000, 32'd3, 32'd1, 32'd7);
        send_word(ACT_LESS, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
        send_word(ACT_NEG,  32'h8000_0000, 32'd1, 0, 1);
    endtask

    task automatic test_each_action();
        send_word(ACT_NORM, 32'd6, 32'd4, 32'd0, 32'd1);
        send_word(ACT_ADD,  32'd1, 32'd2, 32'd1, 32'd3);
        send_word(ACT_SUB,  32'd1, 32'd2, 32'd1, 32'd3);
        send_word(ACT_MUL,  32'd2, 32'd3, -32'd9, 32'd4);
        send_word(ACT_DIV,  32'd2, 32'd3, -32'd9, 32'd4);
        send_word(ACT_LESS, 32'd1, 32'd3, 32'd1, 32'd2);
        send_word(ACT_LESS, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(ACT_NEG,  32'd5, -32'd10, 0, 1);
        send_word(ACT_NONE, 32'd5, 32'd7, 32'd3, 32'd2);
    endtask

    task automatic test_special_cases();
        // zero denominator keeps the numerator
        send_word(ACT_NORM, -32'd12, 32'd0, 0, 1);
        // zero numerator keeps a negative denominator
        send_word(ACT_NORM, 32'd0, -32'd8, 0, 1);
        // negative denominator flips both signs
        send_word(ACT_NORM, 32'd4, -32'd6, 0, 1);
        // shared denominator skips cross-multiplication
        send_word(ACT_ADD, 32'd1, 32'd6, 32'd1, 32'd6);
        send_word(ACT_SUB, 32'd1, 32'd6, 32'd5, 32'd6);
        // division by a zero fraction
        send_word(ACT_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    endtask

    task automatic test_random();
        t_action     act;
        logic [31:0] an, ad, bn, bd;
        repeat (N_RANDOM) begin
            act = ($urandom_range(0, 40) == 0) ? ACT_NONE : t_action'($urandom_range(0, 6));
            an  = pick_operand();
            ad  = pick_operand();
            bn  = pick_operand();
            bd  = ($urandom_range(0, 3) == 0) ? ad : pick_operand();
            send_word(act, an, ad, bn, bd);
        end
    endtask

    initial begin
        n_errors   = 0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_each_action();
        test_special_cases();
        test_random();
        in_ch.valid <= 1'b0;

        // Drain outstanding words, then let the unit settle
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
